@@ sv/gha_pkg.sv @@
// ---------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator.
// ---------------------------------------------------------------------------
package gha_pkg;

    localparam int IDX_W = 8;
    localparam int GEN_W = 32;
    localparam int SLOTS = 2 ** IDX_W;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STALE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } gha_state_t;

    // A freed slot keeps its generation on the stack so that a pop needs
    // no second read of the generation memory.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
    } fs_entry_t;

    typedef struct packed {
        logic      rd;
        logic      pop;
        logic      push;
        fs_entry_t push_entry;
    } fs_ctrl_t;

endpackage

@@ sv/gha_free_stack.sv @@
// ---------------------------------------------------------------------------
// gha_free_stack
// LIFO of freed slots in a synchronous memory with a registered top read.
// ---------------------------------------------------------------------------
module gha_free_stack (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gha_pkg::fs_ctrl_t        ctrl,
    output gha_pkg::fs_entry_t       top_entry,
    output logic [gha_pkg::CNT_W-1:0] depth
);

    gha_pkg::fs_entry_t              mem [gha_pkg::SLOTS];
    gha_pkg::fs_entry_t              top_reg;
    logic [gha_pkg::CNT_W-1:0]       depth_reg;
    logic [gha_pkg::CNT_W-1:0]       depth_next;
    logic [gha_pkg::CNT_W-1:0]       top_addr;

    assign top_addr = depth_reg - gha_pkg::CNT_W'(1);

    always_comb begin
        depth_next = depth_reg;
        if (ctrl.push) begin
            depth_next = depth_reg + gha_pkg::CNT_W'(1);
        end else if (ctrl.pop) begin
            depth_next = depth_reg - gha_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    // Write at the current depth, read the top entry.
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[depth_reg[gha_pkg::IDX_W-1:0]] <= ctrl.push_entry;
        end
        if (ctrl.rd) begin
            top_reg <= mem[top_addr[gha_pkg::IDX_W-1:0]];
        end
    end

    assign top_entry = top_reg;
    assign depth     = depth_reg;

endmodule

@@ sv/generational_handle_allocator_core.sv @@
// ---------------------------------------------------------------------------
// generational_handle_allocator_core
// Hands out (index, generation) handles over a table of slots, frees them
// and checks them; slot generations and freed slots live in memories.
// ---------------------------------------------------------------------------
// Flow: a request beat is taken in S_IDLE, and its result beat is loaded into
//   the output register from S_EXEC once the output register is free.
// A new request is not taken until the result of the last one is loaded; the
//   memories are read at accept and the write-back happens in S_EXEC.
// Reset: synchronous, active low; clears alive bits, counts and valid flags.
//   Memory contents are not cleared; a generation read from an unwritten entry fails the handle check.
// ---------------------------------------------------------------------------
module generational_handle_allocator_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic [gha_pkg::IDX_W-1:0]  s_handle_index,
    input  logic [gha_pkg::GEN_W-1:0]  s_handle_generation,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [gha_pkg::IDX_W-1:0]  m_result_index,
    output logic [gha_pkg::GEN_W-1:0]  m_result_generation
);

    // Control state
    gha_pkg::gha_state_t             state_reg, state_next;
    logic [gha_pkg::CNT_W-1:0]       slots_used_reg, slots_used_next;
    logic [gha_pkg::SLOTS-1:0]       alive_reg, alive_next;
    logic                            m_valid_reg, m_valid_next;

    // Captured request beat
    logic [1:0]                      act_reg;
    logic [gha_pkg::IDX_W-1:0]       idx_reg;
    logic [gha_pkg::GEN_W-1:0]       gen_reg;

    // Result beat
    logic [1:0]                      m_status_reg, m_status_next;
    logic [gha_pkg::IDX_W-1:0]       m_idx_reg, m_idx_next;
    logic [gha_pkg::GEN_W-1:0]       m_gen_reg, m_gen_next;

    // Generation memory
    logic [gha_pkg::GEN_W-1:0]       gen_mem [gha_pkg::SLOTS];
    logic [gha_pkg::GEN_W-1:0]       gen_rd_reg;
    logic                            gen_re;
    logic                            gen_we;
    logic [gha_pkg::IDX_W-1:0]       gen_waddr;
    logic [gha_pkg::GEN_W-1:0]       gen_wdata;

    // Free stack
    gha_pkg::fs_ctrl_t               fs_ctrl;
    gha_pkg::fs_entry_t              fs_top;
    logic [gha_pkg::CNT_W-1:0]       fs_depth;

    logic                            accept;
    logic                            out_free;
    logic                            handle_ok;

    gha_free_stack u_free_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (fs_ctrl),
        .top_entry (fs_top),
        .depth     (fs_depth)
    );

    assign s_ready  = (state_reg == gha_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    // The output register can take a new beat when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    // Read the slot generation at accept; free and lookup compare it in S_EXEC.
    assign gen_re = accept && (s_action == gha_pkg::ACT_FREE ||
                               s_action == gha_pkg::ACT_LOOKUP);

    always_ff @(posedge aclk) begin
        if (gen_we) begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        if (gen_re) begin
            gen_rd_reg <= gen_mem[s_handle_index];
        end
    end

    // Handle check: nonzero generation, index below the used-slot count, generation match, alive.
    assign handle_ok = (gen_reg != '0) &&
                       (gha_pkg::CNT_W'(idx_reg) < slots_used_reg) &&
                       (gen_rd_reg == gen_reg) &&
                       alive_reg[idx_reg];

    always_comb begin
        state_next      = state_reg;
        slots_used_next = slots_used_reg;
        alive_next      = alive_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        m_gen_next      = m_gen_reg;
        gen_we          = 1'b0;
        gen_waddr       = idx_reg;
        gen_wdata       = gen_reg;
        fs_ctrl         = '0;
        fs_ctrl.push_entry.idx = idx_reg;
        fs_ctrl.push_entry.gen = gen_reg;

        case (state_reg)
            gha_pkg::S_IDLE: begin
                if (accept) begin
                    // Fetch the top of the free stack for a possible pop.
                    fs_ctrl.rd = (s_action == gha_pkg::ACT_ALLOC) && (fs_depth != '0);
                    state_next = gha_pkg::S_EXEC;
                end
            end
            gha_pkg::S_EXEC: begin
                // Hold the request until the output register is free.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = gha_pkg::ST_STALE;
                    m_idx_next    = idx_reg;
                    m_gen_next    = gen_reg;
                    state_next    = gha_pkg::S_IDLE;
                    case (act_reg)
                        gha_pkg::ACT_ALLOC: begin
                            if (fs_depth != '0) begin
                                // Reuse the most recently freed slot, bump its generation.
                                fs_ctrl.pop = 1'b1;
                                gen_we      = 1'b1;
                                gen_waddr   = fs_top.idx;
                                gen_wdata   = fs_top.gen + gha_pkg::GEN_W'(1);
                                alive_next[fs_top.idx] = 1'b1;
                                m_status_next = gha_pkg::ST_OK;
                                m_idx_next    = fs_top.idx;
                                m_gen_next    = fs_top.gen + gha_pkg::GEN_W'(1);
                            end else if (slots_used_reg < gha_pkg::CNT_W'(gha_pkg::SLOTS)) begin
                                // Take the next never-used slot at generation one.
                                gen_we          = 1'b1;
                                gen_waddr       = slots_used_reg[gha_pkg::IDX_W-1:0];
                                gen_wdata       = gha_pkg::GEN_W'(1);
                                slots_used_next = slots_used_reg + gha_pkg::CNT_W'(1);
                                alive_next[slots_used_reg[gha_pkg::IDX_W-1:0]] = 1'b1;
                                m_status_next   = gha_pkg::ST_OK;
                                m_idx_next      = slots_used_reg[gha_pkg::IDX_W-1:0];
                                m_gen_next      = gha_pkg::GEN_W'(1);
                            end else begin
                                m_status_next = gha_pkg::ST_FULL;
                            end
                        end
                        gha_pkg::ACT_FREE: begin
                            if (handle_ok) begin
                                // Mark dead and push with its generation.
                                alive_next[idx_reg] = 1'b0;
                                fs_ctrl.push  = (fs_depth < gha_pkg::CNT_W'(gha_pkg::SLOTS));
                                m_status_next = gha_pkg::ST_OK;
                            end
                        end
                        gha_pkg::ACT_LOOKUP: begin
                            if (handle_ok) begin
                                m_status_next = gha_pkg::ST_OK;
                            end
                        end
                        default: begin
                            m_status_next = gha_pkg::ST_STALE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = gha_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gha_pkg::S_IDLE;
            slots_used_reg <= '0;
            alive_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            alive_reg      <= alive_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_action;
            idx_reg <= s_handle_index;
            gen_reg <= s_handle_generation;
        end
        m_status_reg <= m_status_next;
        m_idx_reg    <= m_idx_next;
        m_gen_reg    <= m_gen_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_result_index      = m_idx_reg;
    assign m_result_generation = m_gen_reg;

endmodule

@@ sv/gha_checker.sv @@
// ---------------------------------------------------------------------------
// gha_checker
// Port-level checks of the handle allocator, bound to the top level.
// ---------------------------------------------------------------------------
module gha_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_status,
    input logic [gha_pkg::IDX_W-1:0]  m_result_index,
    input logic [gha_pkg::GEN_W-1:0]  m_result_generation
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // Only the three defined status codes come out.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == gha_pkg::ST_OK || m_status == gha_pkg::ST_STALE ||
                     m_status == gha_pkg::ST_FULL))
        else $error("undefined status code");

    // One request at a time: the cycle after a request beat takes no other.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while one is in flight");

    // A fresh result beat follows a request beat taken before the S_EXEC state that loaded it.
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result beat without a matching request");

    // A stalled result beat holds its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
            $stable(m_result_index) && $stable(m_result_generation))
        else $error("stalled result beat changed");

endmodule

bind generational_handle_allocator_core gha_checker u_gha_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_status            (m_status),
    .m_result_index      (m_result_index),
    .m_result_generation (m_result_generation)
);
